/* sv/emh_pkg.sv */
package emh_pkg;

   localparam int HEAP_DEPTH = 1024;
   localparam int ADDR_W     = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
   localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
   localparam int IDX_W      = ADDR_W + 2;

   localparam int VERTEX_W   = 16;
   localparam int KEY_W      = 32;
   localparam int EDGE_W     = 2 * VERTEX_W + KEY_W;
   localparam int COUNT_OUT_W = 11;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } emh_status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_START,
      S_PUSH_CHK,
      S_PUSH_CMP,
      S_POP_LOAD,
      S_POP_CHK,
      S_POP_LEFT,
      S_POP_CMP,
      S_FINISH
   } emh_state_type;

   typedef struct packed {
      logic           load_item;
      logic           status_load;
      emh_status_type status_code;
      logic           push_begin;
      logic           rd_parent;
      logic           push_shift;
      logic           place_item;
      logic           pop_begin;
      logic           load_moved;
      logic           rd_left;
      logic           load_left;
      logic           rd_right;
      logic           pop_shift;
      logic           place_moved;
      logic           out_load;
   } emh_cmd_type;

   typedef struct packed {
      logic item_pop;
      logic full;
      logic empty;
      logic pos_zero;
      logic parent_le;
      logic child_end;
      logic has_right;
      logic moved_le;
      logic out_busy;
   } emh_flag_type;

   function automatic logic [COUNT_OUT_W-1:0] count_to_out(input logic [CNT_W-1:0] c);
      logic [CNT_W+COUNT_OUT_W-1:0] wide;
      wide = (CNT_W + COUNT_OUT_W)'(c);
      return wide[COUNT_OUT_W-1:0];
   endfunction

endpackage

/* sv/emh_req_if.sv */
interface emh_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [15:0] edge_source;
   logic [15:0] edge_destination;
   logic [31:0] edge_capacity;

   modport source (
      output valid, operation, edge_source, edge_destination, edge_capacity,
      input  ready
   );
   modport sink (
      input  valid, operation, edge_source, edge_destination, edge_capacity,
      output ready
   );
endinterface

/* sv/emh_rsp_if.sv */
interface emh_rsp_if;
   logic        valid;
   logic        ready;
   logic        top_valid;
   logic [15:0] top_source;
   logic [15:0] top_destination;
   logic [31:0] top_key;
   logic [10:0] entry_count;
   logic [1:0]  status;

   modport source (
      output valid, top_valid, top_source, top_destination, top_key, entry_count, status,
      input  ready
   );
   modport sink (
      input  valid, top_valid, top_source, top_destination, top_key, entry_count, status,
      output ready
   );
endinterface

/* sv/edge_min_heap_queue_top.sv */
// Channel   Direction  Transfer when        Payload
// req_bus   in         valid && ready       operation, edge_source, edge_destination,
//                                           edge_capacity
// rsp_bus   out        valid && ready       top_valid, top_source, top_destination, top_key,
//                                           entry_count, status
//
// One operation at a time. A push moves entries up until the root or a parent with a key no
// greater stops it; a pop moves entries down until the end of the heap or a moved key no
// greater than the smaller child stops it. A dropped push or an ignored pop goes straight
// to the finishing state. Reset clears the entry count and the handshake state, not the
// heap memory. A request is accepted while a result waits; the next result then holds in
// the finishing state, and the input stays blocked, until the output register frees.
module edge_min_heap_queue_top
   import emh_pkg::*;
(
   input logic       clock,
   input logic       reset,
   emh_req_if.sink   req_bus,
   emh_rsp_if.source rsp_bus
);

   emh_cmd_type  cmd;
   emh_flag_type flag;

   emh_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_ready (rsp_bus.ready),
      .flag      (flag),
      .cmd       (cmd)
   );

   emh_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .flag                 (flag),
      .req_operation        (req_bus.operation),
      .req_edge_source      (req_bus.edge_source),
      .req_edge_destination (req_bus.edge_destination),
      .req_edge_capacity    (req_bus.edge_capacity),
      .rsp_valid            (rsp_bus.valid),
      .rsp_ready            (rsp_bus.ready),
      .rsp_top_valid        (rsp_bus.top_valid),
      .rsp_top_source       (rsp_bus.top_source),
      .rsp_top_destination  (rsp_bus.top_destination),
      .rsp_top_key          (rsp_bus.top_key),
      .rsp_entry_count      (rsp_bus.entry_count),
      .rsp_status           (rsp_bus.status)
   );

endmodule

/* sv/emh_datapath.sv */
module emh_datapath
   import emh_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  emh_cmd_type            cmd,
   output emh_flag_type           flag,
   input  logic                   req_operation,
   input  logic [VERTEX_W-1:0]    req_edge_source,
   input  logic [VERTEX_W-1:0]    req_edge_destination,
   input  logic [KEY_W-1:0]       req_edge_capacity,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_top_valid,
   output logic [VERTEX_W-1:0]    rsp_top_source,
   output logic [VERTEX_W-1:0]    rsp_top_destination,
   output logic [KEY_W-1:0]       rsp_top_key,
   output logic [COUNT_OUT_W-1:0] rsp_entry_count,
   output logic [1:0]             rsp_status
);

   logic [EDGE_W-1:0] heap_mem [HEAP_DEPTH];

   logic [EDGE_W-1:0]      item_ff, moved_ff, left_ff, rdata_ff, top_ff;
   logic                   item_pop_ff;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [ADDR_W-1:0]      pos_ff, pos_in;
   logic [IDX_W-1:0]       child_ff, child_in;
   emh_status_type         status_ff;

   logic                   rsp_valid_ff;
   logic                   out_top_valid_ff;
   logic [VERTEX_W-1:0]    out_source_ff, out_destination_ff;
   logic [KEY_W-1:0]       out_key_ff;
   logic [COUNT_OUT_W-1:0] out_count_ff;
   logic [1:0]             out_status_ff;

   logic [ADDR_W-1:0] parent_addr, child_addr, right_addr, last_addr, sel_addr, raddr;
   logic [IDX_W-1:0]  right_idx, count_ext;
   logic              has_right, take_right, rd_en, wr_en, top_nonzero;
   logic [EDGE_W-1:0] sel_edge, wdata;

   always_comb begin
      parent_addr = ADDR_W'(pos_ff - ADDR_W'(1)) >> 1;
      child_addr  = child_ff[ADDR_W-1:0];
      right_idx   = child_ff + IDX_W'(1);
      right_addr  = right_idx[ADDR_W-1:0];
      count_ext   = IDX_W'(count_ff);
      last_addr   = ADDR_W'(count_ff - CNT_W'(1));
      has_right   = right_idx < count_ext;
      take_right  = has_right && (rdata_ff[KEY_W-1:0] < left_ff[KEY_W-1:0]);
      sel_edge    = take_right ? rdata_ff : left_ff;
      sel_addr    = take_right ? right_addr : child_addr;

      flag.item_pop  = item_pop_ff;
      flag.full      = count_ff == CNT_W'(HEAP_DEPTH);
      flag.empty     = count_ff == '0;
      flag.pos_zero  = pos_ff == '0;
      flag.parent_le = rdata_ff[KEY_W-1:0] <= item_ff[KEY_W-1:0];
      flag.child_end = child_ff >= count_ext;
      flag.has_right = has_right;
      flag.moved_le  = moved_ff[KEY_W-1:0] <= sel_edge[KEY_W-1:0];
      flag.out_busy  = rsp_valid_ff;

      rd_en = cmd.rd_parent | cmd.rd_left | cmd.rd_right | cmd.pop_begin;
      if (cmd.rd_parent) begin
         raddr = parent_addr;
      end else if (cmd.rd_left) begin
         raddr = child_addr;
      end else if (cmd.rd_right) begin
         raddr = right_addr;
      end else begin
         raddr = last_addr;
      end

      wr_en = cmd.push_shift | cmd.place_item | cmd.pop_shift | cmd.place_moved;
      if (cmd.push_shift) begin
         wdata = rdata_ff;
      end else if (cmd.place_item) begin
         wdata = item_ff;
      end else if (cmd.pop_shift) begin
         wdata = sel_edge;
      end else begin
         wdata = moved_ff;
      end

      count_in = count_ff;
      if (cmd.push_begin) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.pop_begin) begin
         count_in = count_ff - CNT_W'(1);
      end

      pos_in   = pos_ff;
      child_in = child_ff;
      if (cmd.push_begin) begin
         pos_in = ADDR_W'(count_ff);
      end else if (cmd.push_shift) begin
         pos_in = parent_addr;
      end else if (cmd.pop_begin) begin
         pos_in   = '0;
         child_in = IDX_W'(1);
      end else if (cmd.pop_shift) begin
         pos_in   = sel_addr;
         child_in = {1'b0, sel_addr, 1'b1};
      end

      top_nonzero = count_ff != '0;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem[pos_ff] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= heap_mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff   <= pos_in;
      child_ff <= child_in;
      if (cmd.load_item) begin
         item_ff     <= {req_edge_source, req_edge_destination, req_edge_capacity};
         item_pop_ff <= req_operation;
      end
      if (cmd.status_load) begin
         status_ff <= cmd.status_code;
      end
      if (cmd.load_moved) begin
         moved_ff <= rdata_ff;
      end
      if (cmd.load_left) begin
         left_ff <= rdata_ff;
      end
      if (wr_en && pos_ff == '0) begin
         top_ff <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_top_valid_ff   <= top_nonzero;
         out_source_ff      <= top_nonzero ? top_ff[EDGE_W-1 -: VERTEX_W] : '0;
         out_destination_ff <= top_nonzero ? top_ff[KEY_W+VERTEX_W-1 -: VERTEX_W] : '0;
         out_key_ff         <= top_nonzero ? top_ff[KEY_W-1:0] : '0;
         out_count_ff       <= count_to_out(count_ff);
         out_status_ff      <= status_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_top_valid       = out_top_valid_ff;
   assign rsp_top_source      = out_source_ff;
   assign rsp_top_destination = out_destination_ff;
   assign rsp_top_key         = out_key_ff;
   assign rsp_entry_count     = out_count_ff;
   assign rsp_status          = out_status_ff;

endmodule

/* sv/emh_controller.sv */
module emh_controller
   import emh_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic         rsp_ready,
   input  emh_flag_type flag,
   output emh_cmd_type  cmd
);

   emh_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      cmd.status_code = ST_DONE;
      req_ready       = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.load_item   = 1'b1;
               cmd.status_load = 1'b1;
               state_in        = S_START;
            end
         end
         S_START: begin
            if (!flag.item_pop) begin
               if (flag.full) begin
                  cmd.status_load = 1'b1;
                  cmd.status_code = ST_FULL;
                  state_in        = S_FINISH;
               end else begin
                  cmd.push_begin = 1'b1;
                  state_in       = S_PUSH_CHK;
               end
            end else begin
               if (flag.empty) begin
                  cmd.status_load = 1'b1;
                  cmd.status_code = ST_EMPTY;
                  state_in        = S_FINISH;
               end else begin
                  cmd.pop_begin = 1'b1;
                  state_in      = S_POP_LOAD;
               end
            end
         end
         S_PUSH_CHK: begin
            if (flag.pos_zero) begin
               cmd.place_item = 1'b1;
               state_in       = S_FINISH;
            end else begin
               cmd.rd_parent = 1'b1;
               state_in      = S_PUSH_CMP;
            end
         end
         S_PUSH_CMP: begin
            if (flag.parent_le) begin
               cmd.place_item = 1'b1;
               state_in       = S_FINISH;
            end else begin
               cmd.push_shift = 1'b1;
               state_in       = S_PUSH_CHK;
            end
         end
         S_POP_LOAD: begin
            cmd.load_moved = 1'b1;
            state_in       = S_POP_CHK;
         end
         S_POP_CHK: begin
            if (flag.child_end) begin
               cmd.place_moved = 1'b1;
               state_in        = S_FINISH;
            end else begin
               cmd.rd_left = 1'b1;
               state_in    = S_POP_LEFT;
            end
         end
         S_POP_LEFT: begin
            cmd.load_left = 1'b1;
            cmd.rd_right  = flag.has_right;
            state_in      = S_POP_CMP;
         end
         S_POP_CMP: begin
            if (flag.moved_le) begin
               cmd.place_moved = 1'b1;
               state_in        = S_FINISH;
            end else begin
               cmd.pop_shift = 1'b1;
               state_in      = S_POP_CHK;
            end
         end
         S_FINISH: begin
            if (!flag.out_busy || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule
